// ----- src/sars_pkg.sv -----
// Package for the summed-area table region-sum block.
// Field widths, codes, state encoding and controller/datapath structs.
// No dependencies.
`default_nettype none

package sars_pkg;

  // Field widths
  localparam int SIZE_W    = 7;
  localparam int COORD_W   = 6;
  localparam int ELEM_W    = 16;
  localparam int RSUM_W    = 22;
  localparam int SUM_W     = 28;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
  localparam logic [SIZE_W-1:0]    SIZE_RESET   = 7'd64;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CORNER = 2'd1,
    STATUS_NOT_LOADED = 2'd2
  } sars_status_t;

  // Four corners of a region query
  typedef enum logic [1:0] {
    CNR_BR = 2'd0,  // (bottom, right)
    CNR_TR = 2'd1,  // (top-1, right)
    CNR_BL = 2'd2,  // (bottom, left-1)
    CNR_TL = 2'd3   // (top-1, left-1)
  } sars_corner_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WRITE,
    S_Q_RD_BR,
    S_Q_RD_TR,
    S_Q_RD_BL,
    S_Q_RD_TL,
    S_Q_SETTLE,
    S_Q_DONE
  } sars_state_t;

  // Controller to datapath
  typedef struct packed {
    logic         ld_start;
    logic         q_start;
    logic         ld_write;
    logic         q_rd;
    sars_corner_t corner;
    logic         out_load;
  } sars_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_fail;
  } sars_stat_t;

endpackage

`default_nettype wire

// ----- src/sars_item_if.sv -----
// Input item channel: valid/ready handshake with load and query payload.
// Depends on sars_pkg for field widths.
`default_nettype none

interface sars_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [sars_pkg::ELEM_W-1:0]     element_value;
  logic        [sars_pkg::COORD_W-1:0]    top_row;
  logic        [sars_pkg::COORD_W-1:0]    left_col;
  logic        [sars_pkg::COORD_W-1:0]    bottom_row;
  logic        [sars_pkg::COORD_W-1:0]    right_col;

  modport source (
    output valid, mode, element_value, top_row, left_col, bottom_row, right_col,
    input  ready
  );
  modport sink (
    input  valid, mode, element_value, top_row, left_col, bottom_row, right_col,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/sars_result_if.sv -----
// Result channel: valid/ready handshake carrying region sum and status.
// Depends on sars_pkg for field widths.
`default_nettype none

interface sars_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [sars_pkg::SUM_W-1:0]  region_sum;
  logic        [sars_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, region_sum, status,
    input  ready
  );
  modport sink (
    input  valid, region_sum, status,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/sars_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and data.
// Depends on sars_pkg for field widths.
`default_nettype none

interface sars_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sars_pkg::CFG_IDX_W-1:0] index;
  logic [sars_pkg::SIZE_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/sars_ctrl.sv -----
// Controller FSM: sequences table loads and region queries of up to four reads.
// Depends on sars_pkg (state enum, command and status structs).
`default_nettype none

module sars_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_mode,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  sars_pkg::sars_stat_t stat,
  output sars_pkg::sars_cmd_t  cmd
);
  import sars_pkg::*;

  sars_state_t state, state_next;
  logic        out_valid;
  logic        slot_free;

  assign slot_free    = !out_valid || result_ready;
  assign result_valid = out_valid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result slot: set on load, cleared when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (item_mode == MODE_QUERY) ? S_Q_RD_BR : S_LD_WRITE;
        end
      end
      S_LD_WRITE: state_next = S_IDLE;
      S_Q_RD_BR:  state_next = stat.q_fail ? S_Q_DONE : S_Q_RD_TR;
      S_Q_RD_TR:  state_next = S_Q_RD_BL;
      S_Q_RD_BL:  state_next = S_Q_RD_TL;
      S_Q_RD_TL:  state_next = S_Q_SETTLE;
      S_Q_SETTLE: state_next = S_Q_DONE;
      S_Q_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_ready   = 1'b0;
    cmd          = '0;
    cmd.corner   = CNR_BR;
    case (state)
      S_IDLE: begin
        item_ready   = 1'b1;
        cmd.ld_start = item_valid && (item_mode == MODE_LOAD);
        cmd.q_start  = item_valid && (item_mode == MODE_QUERY);
      end
      S_LD_WRITE: cmd.ld_write = 1'b1;
      S_Q_RD_BR: begin
        cmd.q_rd   = !stat.q_fail;
        cmd.corner = CNR_BR;
      end
      S_Q_RD_TR: begin
        cmd.q_rd   = 1'b1;
        cmd.corner = CNR_TR;
      end
      S_Q_RD_BL: begin
        cmd.q_rd   = 1'b1;
        cmd.corner = CNR_BL;
      end
      S_Q_RD_TL: begin
        cmd.q_rd   = 1'b1;
        cmd.corner = CNR_TL;
      end
      S_Q_SETTLE: ;
      S_Q_DONE:   cmd.out_load = slot_free;
      default:    ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/sars_datapath.sv -----
// Datapath: size registers, load position and running sum, prefix table
// memory, query accumulator and result register. Depends on sars_pkg.
`default_nettype none

module sars_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sars_pkg::sars_cmd_t                  cmd,
  output sars_pkg::sars_stat_t                 stat,
  input  logic                                 cfg_write,
  input  logic        [sars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [sars_pkg::SIZE_W-1:0]   cfg_data,
  input  logic signed [sars_pkg::ELEM_W-1:0]   element_value,
  input  logic        [sars_pkg::COORD_W-1:0]  top_row,
  input  logic        [sars_pkg::COORD_W-1:0]  left_col,
  input  logic        [sars_pkg::COORD_W-1:0]  bottom_row,
  input  logic        [sars_pkg::COORD_W-1:0]  right_col,
  output logic signed [sars_pkg::SUM_W-1:0]    region_sum,
  output sars_pkg::sars_status_t               status
);
  import sars_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Row-major table address
  function automatic logic [AW-1:0] tab_addr(input logic [SIZE_W-1:0] row,
                                             input logic [SIZE_W-1:0] col);
    return AW'(row) * AW'(MAX_COLS) + AW'(col);
  endfunction

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [SUM_W-1:0]  table_mem [DEPTH];
  logic [SUM_W-1:0]  rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     corner_addr;

  logic [SIZE_W-1:0] num_rows, num_cols, rows_eff, cols_eff;
  logic [RSUM_W-1:0] row_sum;
  logic [SIZE_W-1:0] load_row, load_col;
  logic              table_ready;

  logic              restart;
  logic [SIZE_W-1:0] ld_row, ld_col;
  logic [RSUM_W-1:0] sum_base, elem_ext;
  logic [SUM_W-1:0]  entry;
  logic [SIZE_W-1:0] col_inc, row_inc;

  logic [SIZE_W-1:0] q_top, q_left, q_bottom, q_right;
  logic [SIZE_W-1:0] in_top, in_left, in_bottom, in_right;
  sars_status_t      q_status, q_status_next;
  logic [SUM_W-1:0]  acc, operand;
  logic              q_data_vld;
  sars_corner_t      corner_q;
  logic              corner_ok;

  assign rows_eff = clamp_size(num_rows, MAX_ROWS);
  assign cols_eff = clamp_size(num_cols, MAX_COLS);

  // Load: restart when a table is complete or the position is off the size
  assign restart  = table_ready || (load_row >= rows_eff) || (load_col >= cols_eff);
  assign ld_row   = restart ? '0 : load_row;
  assign ld_col   = restart ? '0 : load_col;
  assign sum_base = restart ? '0 : row_sum;
  assign elem_ext = {{(RSUM_W - ELEM_W){element_value[ELEM_W-1]}}, element_value};
  assign col_inc  = load_col + SIZE_W'(1);
  assign row_inc  = load_row + SIZE_W'(1);

  // New entry: row running sum plus the entry above (zero on the first row)
  assign entry = {{(SUM_W - RSUM_W){row_sum[RSUM_W-1]}}, row_sum}
               + ((load_row == '0) ? '0 : rd_data);

  // Query corner checks
  assign in_top    = {1'b0, top_row};
  assign in_left   = {1'b0, left_col};
  assign in_bottom = {1'b0, bottom_row};
  assign in_right  = {1'b0, right_col};

  always_comb begin
    if (!table_ready) begin
      q_status_next = STATUS_NOT_LOADED;
    end else if ((in_top > in_bottom) || (in_left > in_right) ||
                 (in_bottom >= rows_eff) || (in_right >= cols_eff)) begin
      q_status_next = STATUS_BAD_CORNER;
    end else begin
      q_status_next = STATUS_OK;
    end
  end

  assign stat.q_fail = (q_status != STATUS_OK);

  // Corner read address
  always_comb begin
    case (cmd.corner)
      CNR_BR:  corner_addr = tab_addr(q_bottom, q_right);
      CNR_TR:  corner_addr = tab_addr(q_top - SIZE_W'(1), q_right);
      CNR_BL:  corner_addr = tab_addr(q_bottom, q_left - SIZE_W'(1));
      CNR_TL:  corner_addr = tab_addr(q_top - SIZE_W'(1), q_left - SIZE_W'(1));
      default: corner_addr = '0;
    endcase
  end

  assign rd_en   = cmd.ld_start || cmd.q_rd;
  assign rd_addr = cmd.ld_start ? tab_addr(ld_row - SIZE_W'(1), ld_col) : corner_addr;

  // Border corners read as zero
  always_comb begin
    case (corner_q)
      CNR_BR:  corner_ok = 1'b1;
      CNR_TR:  corner_ok = (q_top != '0);
      CNR_BL:  corner_ok = (q_left != '0);
      CNR_TL:  corner_ok = (q_top != '0) && (q_left != '0);
      default: corner_ok = 1'b0;
    endcase
  end
  assign operand = corner_ok ? rd_data : '0;

  // Prefix table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ld_write) begin
      table_mem[tab_addr(load_row, load_col)] <= entry;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // Size registers and load position
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows    <= SIZE_RESET;
      num_cols    <= SIZE_RESET;
      row_sum     <= '0;
      load_row    <= '0;
      load_col    <= '0;
      table_ready <= 1'b0;
    end else begin
      if (cmd.ld_start) begin
        load_row <= ld_row;
        load_col <= ld_col;
        row_sum  <= sum_base + elem_ext;
        if (restart) begin
          table_ready <= 1'b0;
        end
      end else if (cmd.ld_write) begin
        if (col_inc >= cols_eff) begin
          load_col <= '0;
          row_sum  <= '0;
          if (row_inc >= rows_eff) begin
            load_row    <= '0;
            table_ready <= 1'b1;
          end else begin
            load_row <= row_inc;
          end
        end else begin
          load_col <= col_inc;
        end
      end
      // A size write restarts loading
      if (cfg_write && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)) begin
        if (cfg_index == REG_NUM_ROWS) begin
          num_rows <= cfg_data;
        end else begin
          num_cols <= cfg_data;
        end
        row_sum     <= '0;
        load_row    <= '0;
        load_col    <= '0;
        table_ready <= 1'b0;
      end
    end
  end

  // Query capture and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      q_data_vld <= 1'b0;
      q_status   <= STATUS_OK;
    end else begin
      q_data_vld <= cmd.q_rd;
      if (cmd.q_start) begin
        q_status <= q_status_next;
      end
    end
  end

  // Query payload and accumulator: +BR -TR -BL +TL
  always_ff @(posedge clk) begin
    corner_q <= cmd.corner;
    if (cmd.q_start) begin
      q_top    <= in_top;
      q_left   <= in_left;
      q_bottom <= in_bottom;
      q_right  <= in_right;
      acc      <= '0;
    end else if (q_data_vld) begin
      if (corner_q == CNR_BR || corner_q == CNR_TL) begin
        acc <= acc + operand;
      end else begin
        acc <= acc - operand;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      region_sum <= acc;
      status     <= q_status;
    end
  end

endmodule

`default_nettype wire

// ----- src/summed_area_table_region_sum_top.sv -----
// Top level of the summed-area table region-sum block.
// Depends on sars_pkg, the channel interfaces, sars_ctrl and sars_datapath.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  item     | in        | mode, element_value, top_row, left_col,
//           |           | bottom_row, right_col
//  result   | out       | region_sum, status (one per query)
//  cfg      | in        | index (0 num_rows, 1 num_cols), data
//
// A load reads the entry above, then writes. A query reads the BR, TR, BL
// and TL corners, settles and loads the result register; it skips the reads
// when its status is not ok. Both follow from the single table read port.
// Reset is synchronous; the table is not cleared and needs no sweep.
// A waiting result holds only a finished query; loads carry on meanwhile.
`default_nettype none

module summed_area_table_region_sum_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic          clk,
  input  logic          rst,
  sars_item_if.sink     item,
  sars_result_if.source result,
  sars_cfg_if.sink      cfg
);
  import sars_pkg::*;

  sars_cmd_t    cmd;
  sars_stat_t   stat;
  sars_status_t status_q;

  assign cfg.ready     = 1'b1;
  assign result.status = status_q;

  sars_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_mode    (item.mode),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  sars_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .element_value (item.element_value),
    .top_row       (item.top_row),
    .left_col      (item.left_col),
    .bottom_row    (item.bottom_row),
    .right_col     (item.right_col),
    .region_sum    (result.region_sum),
    .status        (status_q)
  );

endmodule

`default_nettype wire

// ----- src/sars_checker.sv -----
// Port-level checks for the summed-area table region-sum block,
// bound to the top level. Depends on sars_pkg.
`default_nettype none

module sars_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_ready,
  input logic                                 item_mode,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic signed [sars_pkg::SUM_W-1:0]    region_sum,
  input logic        [sars_pkg::STATUS_W-1:0] status
);
  import sars_pkg::*;

  // A stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(region_sum) && $stable(status)))
    else $error("result changed while stalled");

  // A failed query reports a zero sum
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != STATUS_OK) |-> (region_sum == '0))
    else $error("non-zero sum with failing status");

  // A load transaction never raises a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_mode == MODE_LOAD && !result_valid) |=>
      !result_valid)
    else $error("result raised by a load");

  // A query passes through the controller's query states before any result appears
  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_mode == MODE_QUERY && !result_valid) |=>
      !result_valid)
    else $error("query result too early");

endmodule

bind summed_area_table_region_sum_top sars_checker u_sars_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_mode    (item.mode),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .region_sum   (result.region_sum),
  .status       (result.status)
);

`default_nettype wire

// ----- sim/tb_summed_area_table_region_sum_top.sv -----
// Self-checking testbench for summed_area_table_region_sum_top: loads integral images,
// predicts every region-query answer from a local prefix-sum model and scores results.
// Depends on sars_pkg and the item, result and cfg channel interfaces.
module tb_summed_area_table_region_sum_top;
  import sars_pkg::*;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int TARGET_ITEMS = 1600;
  localparam int LOAD_TAIL    = 8;     // a load may still be writing after the last result
  localparam int END_TAIL     = 20;
  localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on any channel
  localparam int REPORT_LIMIT = 10;

  // Indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic                     mode;
    logic signed [ELEM_W-1:0] elem;
    logic [COORD_W-1:0]       top_row;
    logic [COORD_W-1:0]       left_col;
    logic [COORD_W-1:0]       bottom_row;
    logic [COORD_W-1:0]       right_col;
  } sat_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    sars_status_t            status;
  } region_answer_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // Driven inputs, known from time zero
  logic                     item_valid_q  = 1'b0;
  logic                     item_mode_q   = MODE_LOAD;
  logic signed [ELEM_W-1:0] item_elem_q   = '0;
  logic [COORD_W-1:0]       item_top_q    = '0;
  logic [COORD_W-1:0]       item_left_q   = '0;
  logic [COORD_W-1:0]       item_bottom_q = '0;
  logic [COORD_W-1:0]       item_right_q  = '0;
  logic                     sum_ready_q   = 1'b0;
  logic                     cfg_valid_q   = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_q   = REG_NUM_ROWS;
  logic [SIZE_W-1:0]        cfg_data_q    = SIZE_RESET;

  sars_item_if   item_ch ();
  sars_result_if result_ch ();
  sars_cfg_if    cfg_ch ();

  assign item_ch.valid         = item_valid_q;
  assign item_ch.mode          = item_mode_q;
  assign item_ch.element_value = item_elem_q;
  assign item_ch.top_row       = item_top_q;
  assign item_ch.left_col      = item_left_q;
  assign item_ch.bottom_row    = item_bottom_q;
  assign item_ch.right_col     = item_right_q;
  assign result_ch.ready       = sum_ready_q;
  assign cfg_ch.valid          = cfg_valid_q;
  assign cfg_ch.index          = cfg_index_q;
  assign cfg_ch.data           = cfg_data_q;

  summed_area_table_region_sum_top #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // Stimulus and scoreboard bookkeeping
  sat_item_t      item_backlog[$];
  region_answer_t answers_due[$];
  int items_in_flight = 0;
  int items_queued    = 0;
  int fault_count     = 0;
  int quiet_cycles    = 0;
  int send_idle_pct   = 38;
  int recv_idle_pct   = 61;

  // Predictor state: integral image plus load position
  logic signed [SUM_W-1:0]  sat_table [GRID_ROWS][GRID_COLS];
  logic signed [RSUM_W-1:0] row_acc   = '0;
  int unsigned              fill_row  = 0;
  int unsigned              fill_col  = 0;
  bit                       sat_ready = 1'b0;
  logic [SIZE_W-1:0]        rows_reg  = SIZE_RESET;
  logic [SIZE_W-1:0]        cols_reg  = SIZE_RESET;

  // Stimulus-side view of the load position, to build well-formed tables
  int unsigned plan_rows  = GRID_ROWS;
  int unsigned plan_cols  = GRID_COLS;
  int unsigned plan_cells = GRID_ROWS * GRID_COLS;
  int unsigned plan_pos   = 0;

  // Size register as the block uses it: 0 acts as 1, above max acts as max
  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // One-based read with a zero border above row 0 and left of column 0
  function automatic logic signed [SUM_W-1:0] prefix_at(int unsigned r1, int unsigned c1);
    if (r1 == 0 || c1 == 0) return '0;
    return sat_table[r1-1][c1-1];
  endfunction

  function automatic void restart_fill();
    row_acc   = '0;
    fill_row  = 0;
    fill_col  = 0;
    sat_ready = 1'b0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    if (idx == REG_NUM_ROWS) begin
      rows_reg = val;
      restart_fill();
    end else if (idx == REG_NUM_COLS) begin
      cols_reg = val;
      restart_fill();
    end
  endfunction

  function automatic void predict_load(logic signed [ELEM_W-1:0] v);
    int unsigned rows;
    int unsigned cols;
    rows = clamp_size(rows_reg, GRID_ROWS);
    cols = clamp_size(cols_reg, GRID_COLS);
    if (sat_ready || fill_row >= rows || fill_col >= cols) restart_fill();
    // running row sum wraps at its own width, entry at the table width
    row_acc = row_acc + v;
    sat_table[fill_row][fill_col] = row_acc + prefix_at(fill_row, fill_col + 1);
    fill_col++;
    if (fill_col >= cols) begin
      fill_col = 0;
      row_acc  = '0;
      fill_row++;
      if (fill_row >= rows) begin
        fill_row  = 0;
        sat_ready = 1'b1;
      end
    end
  endfunction

  function automatic region_answer_t predict_query(int unsigned t, int unsigned l,
                                                   int unsigned b, int unsigned r);
    region_answer_t ans;
    int unsigned    rows;
    int unsigned    cols;
    rows       = clamp_size(rows_reg, GRID_ROWS);
    cols       = clamp_size(cols_reg, GRID_COLS);
    ans.sum    = '0;
    ans.status = STATUS_OK;
    if (!sat_ready)
      ans.status = STATUS_NOT_LOADED;
    else if (t > b || l > r || b >= rows || r >= cols)
      ans.status = STATUS_BAD_CORNER;
    else
      ans.sum = prefix_at(b + 1, r + 1) - prefix_at(t, r + 1)
              - prefix_at(b + 1, l) + prefix_at(t, l);
    return ans;
  endfunction

  function automatic void note_fault(string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("[%0t] %s", $time, what);
  endfunction

  // Stimulus building
  function automatic void push_item(sat_item_t it);
    item_backlog = {item_backlog, it};
    items_in_flight++;
    items_queued++;
    if (it.mode == MODE_LOAD) plan_pos = (plan_pos + 1) % plan_cells;
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic void push_load(logic signed [ELEM_W-1:0] v);
    sat_item_t it;
    it.mode       = MODE_LOAD;
    it.elem       = v;
    it.top_row    = COORD_W'($urandom);
    it.left_col   = COORD_W'($urandom);
    it.bottom_row = COORD_W'($urandom);
    it.right_col  = COORD_W'($urandom);
    push_item(it);
  endfunction

  function automatic void push_query(int unsigned t, int unsigned l,
                                     int unsigned b, int unsigned r);
    sat_item_t it;
    it.mode       = MODE_QUERY;
    it.elem       = ELEM_W'($urandom);
    it.top_row    = COORD_W'(t);
    it.left_col   = COORD_W'(l);
    it.bottom_row = COORD_W'(b);
    it.right_col  = COORD_W'(r);
    push_item(it);
  endfunction

  // Corners in order and inside the current size
  function automatic void push_valid_query();
    int unsigned b;
    int unsigned r;
    b = $urandom_range(plan_rows - 1);
    r = $urandom_range(plan_cols - 1);
    push_query($urandom_range(b), $urandom_range(r), b, r);
  endfunction

  function automatic void push_wild_query();
    push_query($urandom_range(63), $urandom_range(63), $urandom_range(63), $urandom_range(63));
  endfunction

  // Finish the table being loaded, or load a whole new one
  function automatic void fill_table();
    repeat (plan_cells - plan_pos) push_load(pick_element());
  endfunction

  function automatic void set_idle();
    if (items_queued < 650) begin
      send_idle_pct = 38;
      recv_idle_pct = 61;
    end else if (items_queued < 1290) begin
      send_idle_pct = 61;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // Wait until every item is taken and answered, then let a trailing load finish
  task automatic settle_block();
    while (items_in_flight != 0 || answers_due.size() != 0) @(posedge clk);
    repeat (LOAD_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid_q <= 1'b0;
    if (idx == REG_NUM_ROWS) plan_rows = clamp_size(val, GRID_ROWS);
    if (idx == REG_NUM_COLS) plan_cols = clamp_size(val, GRID_COLS);
    if (idx == REG_NUM_ROWS || idx == REG_NUM_COLS) begin
      plan_cells = plan_rows * plan_cols;
      plan_pos   = 0;
    end
  endtask

  // Item driver: hold the transaction until taken, then maybe idle
  always @(posedge clk) begin : item_driver
    sat_item_t nxt;
    if (rst) begin
      item_valid_q <= 1'b0;
    end else if (!item_valid_q || item_ch.ready) begin
      if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = item_backlog.pop_front();
        item_valid_q  <= 1'b1;
        item_mode_q   <= nxt.mode;
        item_elem_q   <= nxt.elem;
        item_top_q    <= nxt.top_row;
        item_left_q   <= nxt.left_col;
        item_bottom_q <= nxt.bottom_row;
        item_right_q  <= nxt.right_col;
      end else begin
        item_valid_q <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random
  always @(posedge clk) begin
    sum_ready_q <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: register writes, item prediction, result scoring, watchdog
  always @(posedge clk) begin : monitor
    region_answer_t want;
    bit             moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        apply_reg_write(cfg_ch.index, cfg_ch.data);
      end
      if (item_ch.valid && item_ch.ready) begin
        moved = 1'b1;
        items_in_flight--;
        if (item_ch.mode == MODE_QUERY)
          answers_due = {answers_due,
                         predict_query(item_ch.top_row, item_ch.left_col,
                                       item_ch.bottom_row, item_ch.right_col)};
        else
          predict_load(item_ch.element_value);
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        if (answers_due.size() == 0) begin
          note_fault($sformatf("result with no query pending: sum %0d status %0d",
                               result_ch.region_sum, result_ch.status));
        end else begin
          want = answers_due.pop_front();
          if (result_ch.status !== want.status)
            note_fault($sformatf("status: expected %0d, got %0d",
                                 want.status, result_ch.status));
          if (result_ch.region_sum !== want.sum)
            note_fault($sformatf("region_sum: expected %0d, got %0d",
                                 want.sum, result_ch.region_sum));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    int unsigned phase;
    int unsigned sz_r;
    int unsigned sz_c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Queries before any load report an incomplete table, even with bad corners
    push_query(0, 0, 63, 63);
    push_query(5, 0, 2, 63);
    settle_block();

    // 2 x 3 table with extreme elements
    write_reg(REG_NUM_ROWS, 7'd2);
    write_reg(REG_NUM_COLS, 7'd3);
    push_load(16'sh7FFF);
    push_load(16'sh8000);
    push_load('1);
    push_load('0);
    push_load(16'sd1);
    push_load(16'sh7FFF);
    push_query(0, 0, 1, 2);
    push_query(1, 2, 1, 2);
    push_query(0, 0, 0, 0);
    push_query(1, 0, 0, 2);     // top below bottom
    push_query(0, 2, 1, 1);     // left right of right
    push_query(0, 0, 2, 2);     // bottom past row count
    push_query(0, 0, 1, 3);     // right past column count
    push_query(63, 63, 63, 63);
    // a load after a complete table starts a new one
    push_load(16'sh8000);
    push_query(0, 0, 1, 2);
    repeat (5) push_load(pick_element());
    push_query(0, 0, 1, 2);
    settle_block();

    // Writes to unused indexes must leave the table intact
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    push_query(0, 0, 1, 2);

    // Random phases: new sizes, then rounds of table fills and queries
    phase = 0;
    while (items_queued < TARGET_ITEMS) begin
      settle_block();
      case (phase)
        0: begin sz_r = 0;   sz_c = 3;   end
        1: begin sz_r = 127; sz_c = 2;   end
        2: begin sz_r = 2;   sz_c = 127; end
        3: begin sz_r = 1;   sz_c = 64;  end
        4: begin sz_r = 64;  sz_c = 1;   end
        default: begin
          sz_r = $urandom_range(1, 6);
          sz_c = $urandom_range(1, 6);
          if ($urandom_range(7) == 0) begin
            sz_r = $urandom_range(0, 127);
            sz_c = $urandom_range(0, 3);
          end
        end
      endcase
      set_idle();
      write_reg(REG_NUM_ROWS, SIZE_W'(sz_r));
      write_reg(REG_NUM_COLS, SIZE_W'(sz_c));
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(7))
          // noise: stray loads and arbitrary corners
          0: repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(1) == 0) push_load(pick_element());
            else push_wild_query();
          end
          // broken load: stop part way and query the incomplete table
          1: begin
            repeat ($urandom_range(1, plan_cells)) push_load(pick_element());
            push_valid_query();
            push_wild_query();
          end
          default: ;
        endcase
        fill_table();
        repeat ($urandom_range(3, 8)) begin
          if ($urandom_range(4) == 0) push_wild_query();
          else push_valid_query();
        end
      end
      phase++;
    end

    // Full row count at a narrow width, no idling
    settle_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_NUM_ROWS, SIZE_RESET);
    write_reg(REG_NUM_COLS, 7'd4);
    fill_table();
    push_query(0, 0, 63, 3);
    push_query(63, 3, 63, 3);
    push_query(0, 3, 63, 3);
    push_query(63, 0, 63, 3);
    push_query(0, 0, 63, 63);   // right past column count
    repeat (6) push_valid_query();
    settle_block();
    repeat (END_TAIL) @(posedge clk);

    if (fault_count == 0 && answers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
